[rtl/footprint_grid_collision_check_assert.svh]
// Assertion macros used by footprint_grid_collision_check.sv.
// Each check runs on clk and is held off while arst_n is low.
`ifndef FOOTPRINT_GRID_COLLISION_CHECK_ASSERT_SVH
`define FOOTPRINT_GRID_COLLISION_CHECK_ASSERT_SVH

`ifndef SYNTHESIS

// Condition must hold at every edge.
`define FGCC_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define FGCC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define FGCC_ASSERT(lbl, cond, msg)
`define FGCC_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

[rtl/fgcc_pkg.sv]
package fgcc_pkg;

	// Grid and footprint geometry
	localparam int GRID_SIDE         = 256;
	localparam int GRID_CELLS        = GRID_SIDE * GRID_SIDE;
	localparam int GRID_AW           = $clog2(GRID_CELLS);
	localparam int HALF_LENGTH_STEPS = 10;
	localparam int HALF_WIDTH_STEPS  = 6;
	localparam int STEP_UNITS        = 102;

	// Sine polynomial coefficients (Q14)
	localparam int SIN_A = 25736;
	localparam int SIN_B = 10512;
	localparam int SIN_C = 1160;

	localparam int DIST_MAX = 8388607;

	// Datapath widths
	localparam int CNT_W  = 7;   // signed lattice index
	localparam int DX_W   = 18;  // signed offset in 1/1024 m
	localparam int TRIG_W = 16;  // signed Q14 sin/cos
	localparam int PRD_W  = DX_W + TRIG_W;
	localparam int SUM_W  = PRD_W + 2;
	localparam int POS_W  = 26;  // sample position
	localparam int REL_W  = POS_W + 1;
	localparam int CP_W   = REL_W + 18;
	localparam int SQ_W   = 2 * POS_W;
	localparam int DSQ_W  = SQ_W + 1;
	localparam int SQ_STEPS = (DSQ_W + 1) / 2;
	localparam int IDX_W  = 18;

	// Configuration register indexes
	localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
	localparam logic [2:0] REG_CPM       = 3'd2;
	localparam logic [2:0] REG_WIDTH     = 3'd3;
	localparam logic [2:0] REG_HEIGHT    = 3'd4;
	localparam logic [2:0] REG_THRESHOLD = 3'd5;

	// Input action codes
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRIG,
		ST_SAMPLE,
		ST_DRAIN,
		ST_SQRT,
		ST_OUT
	} state_t;

endpackage

[rtl/footprint_grid_collision_check.sv]
// Footprint collision check against a stored occupancy grid.
// Input channel (in_valid/in_ready): a beat with action = write stores
// cell_value at cell_index in the grid in the cycle it is accepted; a beat
// with action = query checks the footprint at pose_x, pose_y, pose_yaw.
// Output channel (out_valid/out_ready): one beat per query with hit and
// nearest_distance (-1 on a miss); writes give no beat.
// Config channel (cfg_valid/cfg_ready): always ready; cfg_index selects the
// register, cfg_data carries its value. Write only while the block is idle.
// A write item is stored when it is accepted. After a query is accepted, the
// block evaluates the sin/cos polynomial, steps through the 21 x 13 = 273
// lattice samples through the single grid read port, drains the six-stage
// sample pipeline, runs the bit-serial square root of the least squared
// distance in 27 steps and loads the output register.
// in_ready is high only while no query is running, so the next item is taken
// only once the query's result has been loaded into the output register.
// Reset loads the register defaults; grid cells are undefined until written.
// If the receiver stalls, the result waits in the output register; write
// items are still taken, and a following query runs but holds its result
// until the previous beat leaves.
`include "footprint_grid_collision_check_assert.svh"

module footprint_grid_collision_check (
	input  logic                        clk,
	input  logic                        arst_n,
	// config
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [2:0]                  cfg_index,
	input  logic [23:0]                 cfg_data,
	// items in
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        action,
	input  logic [15:0]                 cell_index,
	input  logic signed [7:0]           cell_value,
	input  logic signed [23:0]          pose_x,
	input  logic signed [23:0]          pose_y,
	input  logic [15:0]                 pose_yaw,
	// results out
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        hit,
	output logic signed [23:0]          nearest_distance
);

	import fgcc_pkg::*;

	// Configuration registers
	logic signed [23:0] ox_q, oy_q;
	logic [15:0]        cpm_q;
	logic [8:0]         mw_q, mh_q;
	logic signed [7:0]  thr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q  <= '0;
			oy_q  <= '0;
			cpm_q <= 16'd2560;
			mw_q  <= 9'd256;
			mh_q  <= 9'd256;
			thr_q <= 8'sd50;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ORIGIN_X:  ox_q  <= cfg_data;
				REG_ORIGIN_Y:  oy_q  <= cfg_data;
				REG_CPM:       cpm_q <= cfg_data[15:0];
				REG_WIDTH:     mw_q  <= cfg_data[8:0];
				REG_HEIGHT:    mh_q  <= cfg_data[8:0];
				REG_THRESHOLD: thr_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// FSM
	state_t state_q, state_d;
	logic   in_acc, query_acc, last_sample, pipe_busy, sqrt_done, out_load;
	logic [2:0] trig_step_q;
	logic [$clog2(SQ_STEPS+1)-1:0] sq_cnt_q;
	logic vld_s0, vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	assign in_acc      = in_valid && in_ready;
	assign query_acc   = in_acc && (action == ACT_QUERY);
	assign pipe_busy   = vld_s0 || vld_s1 || vld_s2 || vld_s3 || vld_s4 || vld_s5;
	assign sqrt_done   = (sq_cnt_q == ($bits(sq_cnt_q))'(SQ_STEPS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (query_acc) begin
					state_d = ST_TRIG;
				end
			end
			ST_TRIG: begin
				if (trig_step_q == 3'd4) begin
					state_d = ST_SAMPLE;
				end
			end
			ST_SAMPLE: begin
				if (last_sample) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pipe_busy) begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (sqrt_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Grid memory
	logic                 ram_we, ram_re;
	logic [GRID_AW-1:0]   ram_raddr;
	logic [7:0]           ram_rdata;

	assign ram_we = in_acc && (action == ACT_WRITE) && (32'(cell_index) < GRID_CELLS);

	fgcc_ram #(
		.WIDTH(8),
		.DEPTH(GRID_CELLS)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.waddr(GRID_AW'(cell_index)),
		.wdata(cell_value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Pose capture and sin/cos polynomial, lane 0 = sin, lane 1 = cos
	logic signed [23:0]       px_q, py_q;
	logic [14:0]              t_q [2];
	logic [14:0]              t2_q [2];
	logic [14:0]              v_q [2];
	logic                     neg_q [2];
	logic signed [TRIG_W-1:0] trig_q [2];
	logic [15:0]              ang [2];

	assign ang[0] = pose_yaw;
	assign ang[1] = pose_yaw + 16'd16384;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_step_q <= '0;
		end else if (query_acc) begin
			trig_step_q <= '0;
		end else if (state_q == ST_TRIG) begin
			trig_step_q <= trig_step_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (query_acc) begin
			px_q <= pose_x;
			py_q <= pose_y;
		end
		for (int k = 0; k < 2; k++) begin
			if (query_acc) begin
				t_q[k]   <= ang[k][14] ? (15'd16384 - {1'b0, ang[k][13:0]})
				                       : {1'b0, ang[k][13:0]};
				neg_q[k] <= ang[k][15];
			end else if (state_q == ST_TRIG) begin
				unique case (trig_step_q)
					3'd0: t2_q[k] <= 15'((30'(t_q[k]) * 30'(t_q[k])) >> 14);
					3'd1: v_q[k]  <= 15'(SIN_B) - 15'((30'(SIN_C) * 30'(t2_q[k])) >> 14);
					3'd2: v_q[k]  <= 15'(SIN_A) - 15'((30'(v_q[k]) * 30'(t2_q[k])) >> 14);
					3'd3: v_q[k]  <= 15'((30'(v_q[k]) * 30'(t_q[k])) >> 14);
					default: trig_q[k] <= neg_q[k] ? -$signed({1'b0, v_q[k]})
					                               : $signed({1'b0, v_q[k]});
				endcase
			end
		end
	end

	// Lattice counters
	logic signed [CNT_W-1:0] i_q, j_q;

	assign last_sample = (state_q == ST_SAMPLE) &&
	                     (i_q == CNT_W'(HALF_LENGTH_STEPS)) &&
	                     (j_q == CNT_W'(HALF_WIDTH_STEPS));

	always_ff @(posedge clk) begin
		if (query_acc) begin
			i_q <= -CNT_W'(HALF_LENGTH_STEPS);
			j_q <= -CNT_W'(HALF_WIDTH_STEPS);
		end else if (state_q == ST_SAMPLE) begin
			if (j_q == CNT_W'(HALF_WIDTH_STEPS)) begin
				j_q <= -CNT_W'(HALF_WIDTH_STEPS);
				i_q <= i_q + CNT_W'(1);
			end else begin
				j_q <= j_q + CNT_W'(1);
			end
		end
	end

	// Sample pipeline valid bits
	logic occ_s5;
	logic cell_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s0 <= (state_q == ST_SAMPLE);
			vld_s1 <= vld_s0;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= cell_rd;
		end
	end

	// s0: offsets, s1: rotation products, s2: positions
	logic signed [DX_W-1:0]  dx_s0, dy_s0;
	logic signed [PRD_W-1:0] xc_s1, ys_s1, xs_s1, yc_s1;
	logic signed [SUM_W-1:0] sum_x, sum_y;
	logic signed [POS_W-1:0] pos_s2 [2];

	assign sum_x = SUM_W'(xc_s1) - SUM_W'(ys_s1) + SUM_W'(8192);
	assign sum_y = SUM_W'(xs_s1) + SUM_W'(yc_s1) + SUM_W'(8192);

	always_ff @(posedge clk) begin
		dx_s0 <= DX_W'(i_q) * DX_W'(STEP_UNITS);
		dy_s0 <= DX_W'(j_q) * DX_W'(STEP_UNITS);
		xc_s1 <= PRD_W'(dx_s0) * PRD_W'(trig_q[1]);
		ys_s1 <= PRD_W'(dy_s0) * PRD_W'(trig_q[0]);
		xs_s1 <= PRD_W'(dx_s0) * PRD_W'(trig_q[0]);
		yc_s1 <= PRD_W'(dy_s0) * PRD_W'(trig_q[1]);
		pos_s2[0] <= POS_W'(px_q) + POS_W'(sum_x >>> 14);
		pos_s2[1] <= POS_W'(py_q) + POS_W'(sum_y >>> 14);
	end

	// s3: scale to cells and square, s4: round to cell and range check
	logic signed [CP_W-1:0]  cp_s3 [2];
	logic signed [SQ_W-1:0]  sq_s3 [2];
	logic signed [REL_W-1:0] rel [2];
	logic signed [CP_W-1:0]  cp_r [2];
	logic [CP_W-1:0]         cp_mag [2];
	logic [CP_W-1:0]         cell_q [2];
	logic [8:0]              lim [2];
	logic                    ok_d [2];
	logic [8:0]              cell_s4 [2];
	logic                    ok_s4 [2];
	logic [DSQ_W-1:0]        dsq_s4, dsq_s5;

	assign rel[0] = REL_W'(pos_s2[0]) - REL_W'(ox_q);
	assign rel[1] = REL_W'(pos_s2[1]) - REL_W'(oy_q);
	assign lim[0] = mw_q;
	assign lim[1] = mh_q;

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			cp_r[k]   = cp_s3[k] + CP_W'(131072);
			cp_mag[k] = cp_r[k][CP_W-1] ? CP_W'(-cp_r[k]) : CP_W'(cp_r[k]);
			cell_q[k] = cp_mag[k] >> 18;
			ok_d[k]   = (!cp_r[k][CP_W-1] || (cell_q[k] == '0)) &&
			            (cell_q[k] < CP_W'(lim[k]));
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 2; k++) begin
			cp_s3[k]   <= CP_W'(rel[k]) * CP_W'($signed({1'b0, cpm_q}));
			sq_s3[k]   <= SQ_W'(pos_s2[k]) * SQ_W'(pos_s2[k]);
			cell_s4[k] <= cell_q[k][8:0];
			ok_s4[k]   <= ok_d[k];
		end
		dsq_s4 <= DSQ_W'(unsigned'(sq_s3[0])) + DSQ_W'(unsigned'(sq_s3[1]));
		dsq_s5 <= dsq_s4;
	end

	// s4: cell index and grid read, s5: threshold and running minimum
	logic [IDX_W-1:0] idx;
	logic             hitf_q;
	logic [DSQ_W-1:0] best_q;

	assign idx       = IDX_W'(cell_s4[1]) * IDX_W'(mw_q) + IDX_W'(cell_s4[0]);
	assign cell_rd   = vld_s4 && ok_s4[0] && ok_s4[1] && (32'(idx) < GRID_CELLS);
	assign ram_re    = cell_rd;
	assign ram_raddr = GRID_AW'(idx);
	assign occ_s5    = vld_s5 && ($signed(ram_rdata) > thr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hitf_q <= 1'b0;
		end else if (query_acc) begin
			hitf_q <= 1'b0;
		end else if (occ_s5) begin
			hitf_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (occ_s5 && (!hitf_q || (dsq_s5 < best_q))) begin
			best_q <= dsq_s5;
		end
	end

	// Bit-serial square root of the least squared distance
	logic [DSQ_W-1:0] sq_rem_q, sq_root_q, sq_bit_q, sq_trial;
	logic [DSQ_W-1:0] root_rnd;

	assign sq_trial = sq_root_q + sq_bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_cnt_q <= '0;
		end else if (state_q == ST_DRAIN) begin
			sq_cnt_q <= '0;
		end else if (state_q == ST_SQRT && !sqrt_done) begin
			sq_cnt_q <= sq_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN) begin
			sq_rem_q  <= best_q;
			sq_root_q <= '0;
			sq_bit_q  <= DSQ_W'(1) << (2 * (SQ_STEPS - 1));
		end else if (state_q == ST_SQRT && !sqrt_done) begin
			if (sq_rem_q >= sq_trial) begin
				sq_rem_q  <= sq_rem_q - sq_trial;
				sq_root_q <= (sq_root_q >> 1) + sq_bit_q;
			end else begin
				sq_root_q <= sq_root_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
	end

	assign root_rnd = sq_root_q + DSQ_W'(sq_rem_q > sq_root_q);

	// Output register
	logic              out_valid_q, hit_q;
	logic signed [23:0] dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			hit_q <= hitf_q;
			if (!hitf_q) begin
				dist_q <= '1;
			end else if (root_rnd > DSQ_W'(DIST_MAX)) begin
				dist_q <= 24'(DIST_MAX);
			end else begin
				dist_q <= root_rnd[23:0];
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign hit              = hit_q;
	assign nearest_distance = dist_q;

	// Checks
	`FGCC_ASSERT_IMPL(a_miss_dist, out_valid && !hit, nearest_distance == -24'sd1, "miss without -1 distance")
	`FGCC_ASSERT_IMPL(a_pipe_phase, vld_s0, state_q == ST_SAMPLE || state_q == ST_DRAIN, "sample outside sweep")
	`FGCC_ASSERT_IMPL(a_read_phase, ram_re, state_q == ST_SAMPLE || state_q == ST_DRAIN, "grid read outside sweep")
	`FGCC_ASSERT_IMPL(a_write_idle, ram_we, state_q == ST_IDLE, "grid write during query")

endmodule

[rtl/fgcc_ram.sv]
module fgcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[bench/tb_footprint_grid_collision_check.sv]
`timescale 1ns / 100ps

module tb_footprint_grid_collision_check;
	import fgcc_pkg::*;

	localparam longint CYCLE_LIMIT = 500000;
	// every map setting below reads only cells below this index
	localparam int FILL_CELLS = 256;

	typedef struct {
		bit                 hit;
		logic signed [23:0] distance;
	} collision_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [23:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               action;
	logic [15:0]        cell_index;
	logic signed [7:0]  cell_value;
	logic signed [23:0] pose_x;
	logic signed [23:0] pose_y;
	logic [15:0]        pose_yaw;
	logic               out_valid;
	logic               out_ready;
	logic               hit;
	logic signed [23:0] nearest_distance;

	// shadow of the block's grid and registers
	logic signed [7:0] grid_shadow [GRID_CELLS];
	longint sh_org_x, sh_org_y, sh_cpm, sh_width, sh_height, sh_thr;

	collision_t pending_results[$];
	int     n_fail;
	int     n_queries;
	int     n_hits;
	int     n_writes;
	bit     idle_on;
	longint cycle_cnt;

	footprint_grid_collision_check u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.action           (action),
		.cell_index       (cell_index),
		.cell_value       (cell_value),
		.pose_x           (pose_x),
		.pose_y           (pose_y),
		.pose_yaw         (pose_yaw),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.hit              (hit),
		.nearest_distance (nearest_distance)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Q14 quarter-wave sine polynomial
	function automatic longint sine_q14(input logic [15:0] ang);
		logic [1:0] quad;
		longint t, t2, v;
		quad = ang[15:14];
		t = ang[13:0];
		if (quad[0])
			t = 16384 - t;
		t2 = (t * t) >>> 14;
		v = (SIN_C * t2) >>> 14;
		v = SIN_B - v;
		v = (v * t2) >>> 14;
		v = SIN_A - v;
		v = (v * t) >>> 14;
		return quad[1] ? -v : v;
	endfunction

	function automatic longint pos_to_cell(input longint pos, input longint org);
		longint p;
		p = (pos - org) * sh_cpm + 131072;
		if (p >= 0)
			return p >>> 18;
		return -((-p) >>> 18);
	endfunction

	// integer square root rounded to nearest
	function automatic longint round_sqrt(input longint unsigned s);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s)
			b = b >> 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s = s - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (s > r)
			r = r + 1;
		return r;
	endfunction

	// nearest occupied footprint sample for one pose
	function automatic collision_t predict_footprint(input longint px, input longint py,
			input logic [15:0] yaw);
		collision_t res;
		longint s, c, dx, dy, x, y, u, v, idx, d;
		s = sine_q14(yaw);
		c = sine_q14(yaw + 16'd16384);
		res.hit = 1'b0;
		res.distance = -24'sd1;
		for (int i = -HALF_LENGTH_STEPS; i <= HALF_LENGTH_STEPS; i++) begin
			for (int j = -HALF_WIDTH_STEPS; j <= HALF_WIDTH_STEPS; j++) begin
				dx = i * STEP_UNITS;
				dy = j * STEP_UNITS;
				x = px + ((dx * c - dy * s + 8192) >>> 14);
				y = py + ((dx * s + dy * c + 8192) >>> 14);
				u = pos_to_cell(x, sh_org_x);
				v = pos_to_cell(y, sh_org_y);
				if (u < 0 || u >= sh_width || v < 0 || v >= sh_height)
					continue;
				idx = v * sh_width + u;
				if (idx >= GRID_CELLS)
					continue;
				if (grid_shadow[idx] > sh_thr) begin
					d = round_sqrt(x * x + y * y);
					if (d > DIST_MAX)
						d = DIST_MAX;
					if (!res.hit || d < res.distance)
						res.distance = d[23:0];
					res.hit = 1'b1;
				end
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		n_fail++;
	endtask

	// one input beat; prediction at acceptance
	task automatic send_item(input logic act, input logic [15:0] idx, input logic [7:0] val,
			input longint px, input longint py, input logic [15:0] yaw);
		collision_t res;
		if (idle_on && $urandom_range(99) < 20) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 2)) @(negedge clk);
		end
		action     = act;
		cell_index = idx;
		cell_value = val;
		pose_x     = px[23:0];
		pose_y     = py[23:0];
		pose_yaw   = yaw;
		in_valid   = 1'b1;
		do @(posedge clk); while (!in_ready);
		if (act == ACT_WRITE) begin
			grid_shadow[idx] = val;
			n_writes++;
		end else begin
			res = predict_footprint(px, py, yaw);
			pending_results = {pending_results, res};
			n_queries++;
			if (res.hit)
				n_hits++;
		end
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_query(input longint px, input longint py, input logic [15:0] yaw);
		send_item(ACT_QUERY, 16'($urandom()), 8'($urandom()), px, py, yaw);
	endtask

	// register write once all results are out
	task automatic write_reg(input logic [2:0] idx, input longint val);
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
		cfg_index = idx;
		cfg_data  = val[23:0];
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ORIGIN_X:  sh_org_x = longint'($signed(val[23:0]));
			REG_ORIGIN_Y:  sh_org_y = longint'($signed(val[23:0]));
			REG_CPM:       sh_cpm = val[15:0];
			REG_WIDTH:     sh_width = val[8:0];
			REG_HEIGHT:    sh_height = val[8:0];
			REG_THRESHOLD: sh_thr = longint'($signed(val[7:0]));
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_map(input longint ox, input longint oy, input longint cpm,
			input longint w, input longint h, input longint thr);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_CPM, cpm);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_THRESHOLD, thr);
	endtask

	function automatic longint clip24(input longint v);
		if (v > 8388607)
			return 8388607;
		if (v < -8388608)
			return -8388608;
		return v;
	endfunction

	// low cells written first, so no query reads an unwritten cell
	task automatic test_fill_grid();
		for (int k = 0; k < FILL_CELLS; k++)
			send_item(ACT_WRITE, k[15:0], 8'($urandom()), 0, 0, 16'd0);
	endtask

	// reset register values: two poses off the map, one over row zero only
	task automatic test_reset_map();
		send_query(-8388608, -8388608, 16'd0);
		send_query(8388607, 8388607, 16'd0);
		send_query(2000, -600, 16'd0);
	endtask

	task automatic test_directed();
		send_item(ACT_WRITE, 16'd0, 8'sd127, 0, 0, 16'd0);
		send_item(ACT_WRITE, 16'hFFFF, -8'sd128, 0, 0, 16'd0);
		send_item(ACT_WRITE, 16'd1, -8'sd128, 0, 0, 16'd0);
		// small negative positions truncate onto row and column zero
		send_query(-40, -40, 16'd0);
		send_query(0, 0, 16'd16384);
		send_query(0, 0, 16'd32768);
		send_query(0, 0, 16'd49152);
		send_query(0, 0, 16'hFFFF);
		send_query(13000, 13000, 16'd8192);
		send_query(26000, 26000, 16'd40000);
		send_query(8388607, 8388607, 16'd0);
		send_query(-8388608, -8388608, 16'hFFFF);
		send_query(8388607, -8388608, 16'd12345);
		send_query(-8388608, 8388607, 16'd54321);
	endtask

	// mostly poses over the map, some anywhere, some cell writes
	task automatic test_random_phase(input int n_items);
		longint span, px, py;
		int sel;
		span = (sh_width > sh_height ? sh_width : sh_height) * 262144 / sh_cpm;
		if (span > 8000000)
			span = 8000000;
		for (int k = 0; k < n_items; k++) begin
			sel = $urandom_range(99);
			if (sel < 30) begin
				send_item(ACT_WRITE, 16'($urandom()), 8'($urandom()), 0, 0, 16'd0);
			end else if (sel < 40) begin
				px = longint'($signed(24'($urandom())));
				py = longint'($signed(24'($urandom())));
				send_query(px, py, 16'($urandom()));
			end else begin
				px = clip24(sh_org_x + $urandom_range(0, span + 4000) - 2000);
				py = clip24(sh_org_y + $urandom_range(0, span + 4000) - 2000);
				send_query(px, py, 16'($urandom()));
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin
		collision_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with no query pending");
			end else begin
				exp_res = pending_results.pop_front();
				if (hit !== exp_res.hit)
					report_mismatch($sformatf("hit %0b, want %0b", hit, exp_res.hit));
				if (nearest_distance !== exp_res.distance)
					report_mismatch($sformatf("nearest_distance %0d, want %0d",
						nearest_distance, exp_res.distance));
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		out_ready <= idle_on ? ($urandom_range(99) >= 20) : 1'b1;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_ORIGIN_X;
		cfg_data   = '0;
		in_valid   = 1'b0;
		action     = ACT_WRITE;
		cell_index = '0;
		cell_value = '0;
		pose_x     = '0;
		pose_y     = '0;
		pose_yaw   = '0;
		out_ready  = 1'b0;
		n_fail = 0; n_queries = 0; n_hits = 0; n_writes = 0;
		cycle_cnt = 0;
		idle_on = 1'b1;
		sh_org_x = 0; sh_org_y = 0; sh_cpm = 2560;
		sh_width = 256; sh_height = 256; sh_thr = 50;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_fill_grid();
		test_reset_map();
		// small map over the written cells
		set_map(0, 0, 2560, 16, 16, 50);
		test_directed();
		test_random_phase(36);
		// tiny cells, origin at negative extreme, nearly everything occupied
		set_map(-8388608, -8388608, 65535, 16, 16, -128);
		test_random_phase(36);
		// one huge cell, nothing occupied; no receiver or sender gaps
		idle_on = 1'b0;
		set_map(8388607, -3000, 1, 1, 1, 127);
		test_random_phase(30);
		idle_on = 1'b1;
		set_map(1000, -1000, 512, 256, 1, 0);
		test_random_phase(36);
		set_map(-5000, 3000, 2560, 17, 15, 20);
		test_random_phase(36);

		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (400) @(negedge clk);
		$display("covered %0d cell writes and %0d footprint queries (%0d hits)",
			n_writes, n_queries, n_hits);
		$display("under the reset map and five register settings, %0d mismatches", n_fail);
		if (n_fail == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/fgcc_pkg.sv
rtl/fgcc_ram.sv
rtl/footprint_grid_collision_check.sv
bench/tb_footprint_grid_collision_check.sv
